// ----- design/msab_pkg.sv -----
// ----------------------------------------------------------------------------
// msab_pkg
// Types and constants shared by the movie/sprite alpha blend pipeline.
// ----------------------------------------------------------------------------
package msab_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned LEVEL_W  = 4;
   localparam int unsigned WEIGHT_W = 12;   // holds 0..3825
   localparam int unsigned PROD_W   = CHAN_W + WEIGHT_W;
   localparam int unsigned SUM_W    = 20;   // 255 * 3825 fits in 20 bits
   localparam int unsigned RECIP_W  = 21;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned QUOT_W   = SUM_W + RECIP_W - RECIP_SHIFT;
   localparam int unsigned NUM_CHAN = 3;

   localparam logic [LEVEL_W-1:0]  MIX_MAX     = 4'd15;
   localparam logic [CHAN_W-1:0]   CHAN_MAX    = 8'd255;
   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 12'd3825;
   // ceil(2^32 / 3825); exact floor division for every sum below 2^20
   localparam logic [RECIP_W-1:0]  RECIP_FULL  = 21'd1122868;

   typedef struct packed {
      logic [CHAN_W-1:0] movie_red;
      logic [CHAN_W-1:0] movie_green;
      logic [CHAN_W-1:0] movie_blue;
      logic [CHAN_W-1:0] sprite_alpha;
      logic [CHAN_W-1:0] sprite_red;
      logic [CHAN_W-1:0] sprite_green;
      logic [CHAN_W-1:0] sprite_blue;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mixed_red;
      logic [CHAN_W-1:0] mixed_green;
      logic [CHAN_W-1:0] mixed_blue;
      logic [CHAN_W-1:0] mixed_alpha;
   } rsp_word_type;

endpackage

// ----- design/movie_sprite_alpha_blend.sv -----
// ----------------------------------------------------------------------------
// movie_sprite_alpha_blend
// Pixel mixer: blends a sprite ARGB pixel over a movie RGB pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word on req_pixel and raise start; the word is taken at every
//   rising edge where start is high and busy is low. busy stays low, so one
//   pixel can enter on every clock.
//   Each result appears on rsp_pixel for exactly one cycle with rsp_strobe
//   high, once it has passed the weight, product, sum and quotient
//   registers, in input order. The receiver must take it in that cycle.
//   csr_wr_en/csr_wr_data write the global mix level (0..15); change it only
//   while no pixel is in flight.
//   Datapath: weight multiply, channel products, sum, then a reciprocal
//   multiply for the divide by 3825, one register stage each.
//   Reset (synchronous, active high) clears the mix level to zero, which
//   passes the movie pixel through, and empties the pipeline.
// ----------------------------------------------------------------------------
module movie_sprite_alpha_blend (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  msab_pkg::req_word_type                req_pixel,
   output logic                                  rsp_strobe,
   output msab_pkg::rsp_word_type                rsp_pixel,
   input  logic                                  csr_wr_en,
   input  logic [msab_pkg::LEVEL_W-1:0]          csr_wr_data
);

   logic [msab_pkg::LEVEL_W-1:0] mix_level_ff, mix_level_in;

   // stage 1: weights
   logic                          s1_valid_ff, s1_valid_in;
   logic [msab_pkg::WEIGHT_W-1:0] s1_w_ff, s1_w_in;
   logic [msab_pkg::WEIGHT_W-1:0] s1_wbar_ff, s1_wbar_in;
   logic [msab_pkg::CHAN_W-1:0]   s1_movie_ff [msab_pkg::NUM_CHAN];
   logic [msab_pkg::CHAN_W-1:0]   s1_sprite_ff [msab_pkg::NUM_CHAN];

   // stage 2: products
   logic                        s2_valid_ff;
   logic [msab_pkg::PROD_W-1:0] s2_pm_ff [msab_pkg::NUM_CHAN];
   logic [msab_pkg::PROD_W-1:0] s2_ps_ff [msab_pkg::NUM_CHAN];
   logic [msab_pkg::PROD_W-1:0] s2_pm_in [msab_pkg::NUM_CHAN];
   logic [msab_pkg::PROD_W-1:0] s2_ps_in [msab_pkg::NUM_CHAN];

   // stage 3: sums
   logic                       s3_valid_ff;
   logic [msab_pkg::SUM_W-1:0] s3_sum_ff [msab_pkg::NUM_CHAN];
   logic [msab_pkg::SUM_W-1:0] s3_sum_in [msab_pkg::NUM_CHAN];

   // stage 4: quotient, capped
   logic                        s4_valid_ff;
   logic [msab_pkg::CHAN_W-1:0] s4_chan_ff [msab_pkg::NUM_CHAN];
   logic [msab_pkg::CHAN_W-1:0] s4_chan_in [msab_pkg::NUM_CHAN];

   logic [msab_pkg::CHAN_W-1:0] in_movie  [msab_pkg::NUM_CHAN];
   logic [msab_pkg::CHAN_W-1:0] in_sprite [msab_pkg::NUM_CHAN];

   assign busy = 1'b0;

   assign in_movie[0]  = req_pixel.movie_red;
   assign in_movie[1]  = req_pixel.movie_green;
   assign in_movie[2]  = req_pixel.movie_blue;
   assign in_sprite[0] = req_pixel.sprite_red;
   assign in_sprite[1] = req_pixel.sprite_green;
   assign in_sprite[2] = req_pixel.sprite_blue;

   // saturate the level; with a 4-bit port this only guards the range
   always_comb begin
      mix_level_in = mix_level_ff;
      if (csr_wr_en) begin
         mix_level_in = (csr_wr_data > msab_pkg::MIX_MAX) ? msab_pkg::MIX_MAX
                                                          : csr_wr_data;
      end
   end

   always_comb begin
      s1_valid_in = start & ~busy;
      s1_w_in     = msab_pkg::WEIGHT_W'(req_pixel.sprite_alpha * mix_level_ff);
      s1_wbar_in  = msab_pkg::WEIGHT_FULL - s1_w_in;
   end

   always_comb begin
      for (int c = 0; c < msab_pkg::NUM_CHAN; c++) begin
         s2_pm_in[c] = msab_pkg::PROD_W'(s1_movie_ff[c] * s1_wbar_ff);
         s2_ps_in[c] = msab_pkg::PROD_W'(s1_sprite_ff[c] * s1_w_ff);
      end
   end

   always_comb begin
      for (int c = 0; c < msab_pkg::NUM_CHAN; c++) begin
         s3_sum_in[c] = msab_pkg::SUM_W'(s2_pm_ff[c] + s2_ps_ff[c]);
      end
   end

   // divide by 3825 through the reciprocal, then cap
   always_comb begin
      logic [msab_pkg::SUM_W+msab_pkg::RECIP_W-1:0] prod;
      logic [msab_pkg::QUOT_W-1:0]                  quot;
      for (int c = 0; c < msab_pkg::NUM_CHAN; c++) begin
         prod = (msab_pkg::SUM_W+msab_pkg::RECIP_W)'(s3_sum_ff[c])
              * (msab_pkg::SUM_W+msab_pkg::RECIP_W)'(msab_pkg::RECIP_FULL);
         quot = prod[msab_pkg::SUM_W+msab_pkg::RECIP_W-1:msab_pkg::RECIP_SHIFT];
         s4_chan_in[c] = (quot > msab_pkg::QUOT_W'(msab_pkg::CHAN_MAX))
                       ? msab_pkg::CHAN_MAX : msab_pkg::CHAN_W'(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_level_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
      end else begin
         mix_level_ff <= mix_level_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
      end
   end

   // payload advances every cycle; valid bits mark the live words
   always_ff @(posedge clock) begin
      s1_w_ff    <= s1_w_in;
      s1_wbar_ff <= s1_wbar_in;
      for (int c = 0; c < msab_pkg::NUM_CHAN; c++) begin
         s1_movie_ff[c]  <= in_movie[c];
         s1_sprite_ff[c] <= in_sprite[c];
         s2_pm_ff[c]     <= s2_pm_in[c];
         s2_ps_ff[c]     <= s2_ps_in[c];
         s3_sum_ff[c]    <= s3_sum_in[c];
         s4_chan_ff[c]   <= s4_chan_in[c];
      end
   end

   assign rsp_strobe            = s4_valid_ff;
   assign rsp_pixel.mixed_red   = s4_chan_ff[0];
   assign rsp_pixel.mixed_green = s4_chan_ff[1];
   assign rsp_pixel.mixed_blue  = s4_chan_ff[2];
   assign rsp_pixel.mixed_alpha = msab_pkg::CHAN_MAX;

endmodule
